// ===== rtl/dopc_pkg.sv =====
// ----------------------------------------------------------------------------
// dopc_pkg
// Types, option table and value checks shared by the DHCP option payload
// checker modules.
// ----------------------------------------------------------------------------
package dopc_pkg;

  typedef enum logic {
    REQ_HEADER  = 1'b0,
    REQ_PAYLOAD = 1'b1
  } req_type_e;

  typedef enum logic [3:0] {
    KIND_SUBNET_MASK = 4'd0,
    KIND_INT32       = 4'd1,
    KIND_IP_ADDR     = 4'd2,
    KIND_STRING      = 4'd3,
    KIND_UINT16      = 4'd4,
    KIND_FLAG        = 4'd5,
    KIND_IP_MASK     = 4'd6,
    KIND_UINT8       = 4'd7,
    KIND_UINT32      = 4'd8,
    KIND_IP_PAIR     = 4'd9,
    KIND_ENUM        = 4'd10,
    KIND_VENDOR      = 4'd11,
    KIND_BYTE_ARRAY  = 4'd12,
    KIND_NONE        = 4'd13,
    KIND_UNKNOWN     = 4'd14
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_UNKNOWN_CODE = 3'd1,
    ST_EMPTY_TYPE   = 3'd2,
    ST_LEN_MISMATCH = 3'd3,
    ST_BELOW_MIN    = 3'd4,
    ST_CONSTRAINT   = 3'd5,
    ST_PARTIAL      = 3'd6,
    ST_STRAY        = 3'd7
  } status_e;

  // option codes with special handling
  localparam logic [7:0] OPT_MAX_REASSEMBLY = 8'd22;
  localparam logic [7:0] OPT_DEFAULT_TTL    = 8'd23;
  localparam logic [7:0] OPT_IF_MTU         = 8'd26;
  localparam logic [7:0] OPT_TCP_TTL        = 8'd37;
  localparam logic [7:0] OPT_NBNS_NODE_TYPE = 8'd46;
  localparam logic [7:0] OPT_OVERLOAD       = 8'd52;
  localparam logic [7:0] OPT_MSG_TYPE       = 8'd53;
  localparam logic [7:0] OPT_MAX_MSG_SIZE   = 8'd57;
  localparam logic [7:0] OPT_CLIENT_ID      = 8'd61;
  localparam logic [7:0] OPT_END            = 8'd255;

  localparam logic [7:0] LEN_VAR      = 8'hFF;
  localparam logic [7:0] ROM_CODES    = 8'd77;
  localparam logic [63:0] MIN_MSG_SIZE = 64'd576;
  localparam logic [63:0] MIN_MTU      = 64'd68;

  typedef struct packed {
    logic       req_type;
    logic [7:0] opt_code;
    logic [7:0] opt_length;
    logic [7:0] payload_byte;
  } dopc_req_t;

  typedef struct packed {
    logic [63:0] element_value;
    logic [3:0]  value_kind;
    logic [2:0]  status;
    logic        is_last;
  } dopc_rsp_t;

  typedef struct packed {
    logic        option_open;
    logic        option_failed;
    kind_e       current_type;
    logic [7:0]  current_code;
    logic [7:0]  bytes_left;
    logic [2:0]  elem_seen;
    logic [63:0] elem_acc;
  } dopc_state_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] flen;
  } rom_entry_t;

  function automatic rom_entry_t rom_lookup(input logic [7:0] code);
    rom_entry_t e;
    e.kind = KIND_IP_ADDR;
    e.flen = LEN_VAR;
    case (code)
      8'd0:   begin e.kind = KIND_NONE;        e.flen = 8'd0; end
      8'd1:   begin e.kind = KIND_SUBNET_MASK; e.flen = 8'd4; end
      8'd2:   begin e.kind = KIND_INT32;       e.flen = 8'd4; end
      8'd12, 8'd14, 8'd15, 8'd17, 8'd18, 8'd40, 8'd47, 8'd56, 8'd60, 8'd64, 8'd66,
      8'd67:  begin e.kind = KIND_STRING;      e.flen = LEN_VAR; end
      8'd13, 8'd22, 8'd26, 8'd57:
              begin e.kind = KIND_UINT16;      e.flen = 8'd2; end
      8'd25:  begin e.kind = KIND_UINT16;      e.flen = LEN_VAR; end
      8'd16, 8'd28, 8'd32, 8'd50, 8'd54:
              begin e.kind = KIND_IP_ADDR;     e.flen = 8'd4; end
      8'd19, 8'd20, 8'd27, 8'd29, 8'd30, 8'd31, 8'd34, 8'd36, 8'd39:
              begin e.kind = KIND_FLAG;        e.flen = 8'd1; end
      8'd21:  begin e.kind = KIND_IP_MASK;     e.flen = LEN_VAR; end
      8'd23, 8'd37:
              begin e.kind = KIND_UINT8;       e.flen = 8'd1; end
      8'd24, 8'd35, 8'd38, 8'd51, 8'd58, 8'd59:
              begin e.kind = KIND_UINT32;      e.flen = 8'd4; end
      8'd33:  begin e.kind = KIND_IP_PAIR;     e.flen = LEN_VAR; end
      8'd43:  begin e.kind = KIND_VENDOR;      e.flen = LEN_VAR; end
      8'd46, 8'd52, 8'd53:
              begin e.kind = KIND_ENUM;        e.flen = 8'd1; end
      8'd55, 8'd61:
              begin e.kind = KIND_BYTE_ARRAY;  e.flen = LEN_VAR; end
      8'd62, 8'd63:
              begin e.kind = KIND_UNKNOWN;     e.flen = 8'd0; end
      default: begin
        if (code == OPT_END) begin
          e.kind = KIND_NONE;
          e.flen = 8'd0;
        end else if (code >= ROM_CODES) begin
          e.kind = KIND_UNKNOWN;
          e.flen = 8'd0;
        end
      end
    endcase
    return e;
  endfunction

  function automatic logic [3:0] elem_size(input kind_e k);
    logic [3:0] s;
    case (k)
      KIND_UINT16: s = 4'd2;
      KIND_SUBNET_MASK, KIND_INT32, KIND_IP_ADDR, KIND_UINT32: s = 4'd4;
      KIND_IP_MASK, KIND_IP_PAIR: s = 4'd8;
      default: s = 4'd1;
    endcase
    return s;
  endfunction

  function automatic status_e check_value(input logic [7:0] code, input logic [63:0] v);
    status_e st;
    st = ST_OK;
    case (code)
      OPT_MAX_REASSEMBLY, OPT_MAX_MSG_SIZE: st = (v >= MIN_MSG_SIZE) ? ST_OK : ST_BELOW_MIN;
      OPT_IF_MTU:  st = (v >= MIN_MTU) ? ST_OK : ST_BELOW_MIN;
      OPT_TCP_TTL: st = (v != 64'd0) ? ST_OK : ST_BELOW_MIN;
      OPT_DEFAULT_TTL:
        st = (v >= 64'd1 && v <= 64'd255) ? ST_OK : ST_CONSTRAINT;
      OPT_NBNS_NODE_TYPE:
        st = (v == 64'd1 || v == 64'd2 || v == 64'd4 || v == 64'd8) ? ST_OK : ST_CONSTRAINT;
      OPT_OVERLOAD:
        st = (v >= 64'd1 && v <= 64'd3) ? ST_OK : ST_CONSTRAINT;
      OPT_MSG_TYPE:
        st = (v >= 64'd1 && v <= 64'd8) ? ST_OK : ST_CONSTRAINT;
      default: st = ST_OK;
    endcase
    return st;
  endfunction

endpackage

// ===== rtl/dhcp_option_payload_checker.sv =====
// an input transfer is held in the input register, and its result then in the result register that drives rsp_valid_o
// throughput: one item per cycle while the result side keeps taking transfers
// an item that gives no result still takes one slot of the input register
// reset clears the option state and both valid flags; the block is ready at once
// ----------------------------------------------------------------------------
// dhcp_option_payload_checker
// Checks and decodes DHCP options: header lookup, element gathering and value
// checks, with an input register and a result register.
// ----------------------------------------------------------------------------
module dhcp_option_payload_checker import dopc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  dopc_req_t req_i,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output dopc_rsp_t rsp_o
);

  logic        s1_valid_q, s1_valid_d;
  dopc_req_t   s1_req_q;
  dopc_state_t state_q;
  dopc_state_t state_d;
  logic        out_valid_q;
  dopc_rsp_t   out_q;
  logic        step_valid;
  dopc_rsp_t   step_rsp;
  logic        advance;
  logic        in_xfer;

  assign advance     = s1_valid_q && (!out_valid_q || rsp_ready_i);
  assign req_ready_o = !s1_valid_q || advance;
  assign in_xfer     = req_valid_i && req_ready_o;
  assign s1_valid_d  = in_xfer || (s1_valid_q && !advance);

  dopc_step u_step (
    .state_i     (state_q),
    .req_i       (s1_req_q),
    .state_o     (state_d),
    .rsp_valid_o (step_valid),
    .rsp_o       (step_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= step_valid;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_req_q <= req_i;
    end
    if (advance && step_valid) begin
      out_q <= step_rsp;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

// ===== rtl/dopc_step.sv =====
// ----------------------------------------------------------------------------
// dopc_step
// Per-item decode: header lookup and checks, byte gathering, element checks
// and the next option state.
// ----------------------------------------------------------------------------
module dopc_step import dopc_pkg::*; (
  input  dopc_state_t state_i,
  input  dopc_req_t   req_i,
  output dopc_state_t state_o,
  output logic        rsp_valid_o,
  output dopc_rsp_t   rsp_o
);

  rom_entry_t  ent;
  status_e     hdr_st;
  logic [7:0]  min_len;
  logic [7:0]  left_dec;
  logic        last;
  logic [63:0] acc_shift;
  logic [3:0]  seen_inc;
  logic [63:0] elem_val;
  status_e     elem_st;

  always_comb begin
    ent     = rom_lookup(req_i.opt_code);
    min_len = (req_i.opt_code == OPT_CLIENT_ID) ? 8'd2 : 8'd1;
    if (ent.kind == KIND_UNKNOWN) begin
      hdr_st = ST_UNKNOWN_CODE;
    end else if (ent.flen != LEN_VAR && ent.flen != req_i.opt_length) begin
      hdr_st = ST_LEN_MISMATCH;
    end else if (ent.kind == KIND_NONE) begin
      hdr_st = ST_EMPTY_TYPE;
    end else if (ent.kind == KIND_BYTE_ARRAY && req_i.opt_length < min_len) begin
      hdr_st = ST_BELOW_MIN;
    end else begin
      hdr_st = ST_OK;
    end

    left_dec  = state_i.bytes_left - 8'd1;
    last      = (left_dec == 8'd0);
    acc_shift = {state_i.elem_acc[55:0], req_i.payload_byte};
    seen_inc  = {1'b0, state_i.elem_seen} + 4'd1;
    elem_val  = acc_shift;
    elem_st   = ST_OK;
    if (state_i.current_type == KIND_FLAG) begin
      elem_val = {63'd0, (acc_shift != 64'd0)};
    end else if (state_i.current_type == KIND_UINT8 || state_i.current_type == KIND_UINT16 ||
                 state_i.current_type == KIND_UINT32 || state_i.current_type == KIND_ENUM) begin
      elem_st = check_value(state_i.current_code, acc_shift);
    end

    state_o     = state_i;
    rsp_valid_o = 1'b0;
    rsp_o       = '0;

    if (req_i.req_type == REQ_HEADER) begin
      state_o.elem_acc      = '0;
      state_o.elem_seen     = '0;
      state_o.current_code  = req_i.opt_code;
      state_o.current_type  = (hdr_st != ST_OK) ? KIND_SUBNET_MASK : ent.kind;
      state_o.bytes_left    = req_i.opt_length;
      state_o.option_open   = (req_i.opt_length != 8'd0);
      state_o.option_failed = (req_i.opt_length != 8'd0) && (hdr_st != ST_OK);
      if (hdr_st != ST_OK) begin
        rsp_valid_o   = 1'b1;
        rsp_o.status  = hdr_st;
        rsp_o.is_last = 1'b1;
      end
    end else if (!state_i.option_open) begin
      rsp_valid_o         = 1'b1;
      rsp_o.element_value = {56'd0, req_i.payload_byte};
      rsp_o.status        = ST_STRAY;
    end else begin
      state_o.bytes_left = left_dec;
      if (last) begin
        state_o.option_open = 1'b0;
      end
      if (state_i.option_failed) begin
        if (last) begin
          state_o.option_failed = 1'b0;
        end
      end else if (state_i.current_type == KIND_STRING ||
                   state_i.current_type == KIND_BYTE_ARRAY ||
                   state_i.current_type == KIND_VENDOR) begin
        rsp_valid_o         = 1'b1;
        rsp_o.element_value = {56'd0, req_i.payload_byte};
        rsp_o.value_kind    = state_i.current_type;
        rsp_o.is_last       = last;
      end else if (seen_inc >= elem_size(state_i.current_type)) begin
        state_o.elem_acc    = '0;
        state_o.elem_seen   = '0;
        rsp_valid_o         = 1'b1;
        rsp_o.element_value = elem_val;
        rsp_o.value_kind    = state_i.current_type;
        rsp_o.status        = elem_st;
        rsp_o.is_last       = last;
      end else if (last) begin
        state_o.elem_acc    = '0;
        state_o.elem_seen   = '0;
        rsp_valid_o         = 1'b1;
        rsp_o.element_value = acc_shift;
        rsp_o.value_kind    = state_i.current_type;
        rsp_o.status        = ST_PARTIAL;
        rsp_o.is_last       = 1'b1;
      end else begin
        state_o.elem_acc  = acc_shift;
        state_o.elem_seen = seen_inc[2:0];
      end
    end
  end

endmodule

// ===== rtl/dopc_checker.sv =====
// ----------------------------------------------------------------------------
// dopc_checker
// Port-level assertions for the DHCP option payload checker, bound to the
// top level.
// ----------------------------------------------------------------------------
module dopc_checker import dopc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      req_valid_i,
  input logic      req_ready_o,
  input dopc_req_t req_i,
  input logic      rsp_valid_o,
  input logic      rsp_ready_i,
  input dopc_rsp_t rsp_o
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed while stalled");

  // input side is never blocked while the result side drains
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!rsp_valid_o || rsp_ready_i) |-> req_ready_o)
    else $error("input not ready while output free");

  // a fresh result traces back to an input transfer held in the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(req_valid_i && req_ready_o, 2))
    else $error("result without matching input transfer");

  // stray bytes never close an option
  a_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status == ST_STRAY |->
      !rsp_o.is_last && rsp_o.value_kind == KIND_SUBNET_MASK)
    else $error("bad stray byte result");

endmodule

bind dhcp_option_payload_checker dopc_checker u_dopc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .req_i       (req_i),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

// ===== verif/tb_dhcp_option_payload_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dhcp_option_payload_checker
// Drives option headers, payload bytes and stray bytes into the DHCP option
// payload checker and compares every result against a local decoder model.
// ----------------------------------------------------------------------------
module tb_dhcp_option_payload_checker import dopc_pkg::*; ();

  class dhcp_option_tracker;
    bit          is_open;
    bit          is_failed;
    kind_e       cur_kind;
    logic [7:0]  cur_code;
    logic [7:0]  bytes_left;
    logic [2:0]  elem_seen;
    logic [63:0] elem_acc;
    dopc_rsp_t   pending_elements[$];
    int unsigned fed;
    int unsigned errors;

    function void table_entry(input logic [7:0] code, output kind_e k,
                              output logic [7:0] flen);
      k    = KIND_IP_ADDR;
      flen = LEN_VAR;
      case (code)
        8'd0, 8'd255: begin k = KIND_NONE; flen = 8'd0; end
        8'd1: begin k = KIND_SUBNET_MASK; flen = 8'd4; end
        8'd2: begin k = KIND_INT32; flen = 8'd4; end
        8'd12, 8'd14, 8'd15, 8'd17, 8'd18, 8'd40, 8'd47, 8'd56, 8'd60, 8'd64, 8'd66, 8'd67:
          k = KIND_STRING;
        8'd13, 8'd22, 8'd26, 8'd57: begin k = KIND_UINT16; flen = 8'd2; end
        8'd25: k = KIND_UINT16;
        8'd16, 8'd28, 8'd32, 8'd50, 8'd54: flen = 8'd4;
        8'd19, 8'd20, 8'd27, 8'd29, 8'd30, 8'd31, 8'd34, 8'd36, 8'd39: begin
          k    = KIND_FLAG;
          flen = 8'd1;
        end
        8'd21: k = KIND_IP_MASK;
        8'd23, 8'd37: begin k = KIND_UINT8; flen = 8'd1; end
        8'd24, 8'd35, 8'd38, 8'd51, 8'd58, 8'd59: begin k = KIND_UINT32; flen = 8'd4; end
        8'd33: k = KIND_IP_PAIR;
        8'd43: k = KIND_VENDOR;
        8'd46, 8'd52, 8'd53: begin k = KIND_ENUM; flen = 8'd1; end
        8'd55, 8'd61: k = KIND_BYTE_ARRAY;
        8'd62, 8'd63: begin k = KIND_UNKNOWN; flen = 8'd0; end
        default: begin
          if (code >= 8'd77) begin
            k    = KIND_UNKNOWN;
            flen = 8'd0;
          end
        end
      endcase
    endfunction

    function logic [3:0] bytes_per_element(input kind_e k);
      case (k)
        KIND_UINT16: return 4'd2;
        KIND_SUBNET_MASK, KIND_INT32, KIND_IP_ADDR, KIND_UINT32: return 4'd4;
        KIND_IP_MASK, KIND_IP_PAIR: return 4'd8;
        default: return 4'd1;
      endcase
    endfunction

    function status_e value_status(input logic [7:0] code, input logic [63:0] v);
      case (code)
        OPT_MAX_REASSEMBLY, OPT_MAX_MSG_SIZE: return (v >= 64'd576) ? ST_OK : ST_BELOW_MIN;
        OPT_IF_MTU: return (v >= 64'd68) ? ST_OK : ST_BELOW_MIN;
        OPT_TCP_TTL: return (v >= 64'd1) ? ST_OK : ST_BELOW_MIN;
        OPT_DEFAULT_TTL: return (v >= 64'd1 && v <= 64'd255) ? ST_OK : ST_CONSTRAINT;
        OPT_NBNS_NODE_TYPE:
          return (v == 64'd1 || v == 64'd2 || v == 64'd4 || v == 64'd8) ? ST_OK : ST_CONSTRAINT;
        OPT_OVERLOAD: return (v >= 64'd1 && v <= 64'd3) ? ST_OK : ST_CONSTRAINT;
        OPT_MSG_TYPE: return (v >= 64'd1 && v <= 64'd8) ? ST_OK : ST_CONSTRAINT;
        default: return ST_OK;
      endcase
    endfunction

    function void expect_element(input logic [63:0] v, input kind_e k, input status_e st,
                                 input bit last);
      dopc_rsp_t e;
      e.element_value = v;
      e.value_kind    = k;
      e.status        = st;
      e.is_last       = last;
      pending_elements = {pending_elements, e};
    endfunction

    function void take_request(input dopc_req_t r);
      kind_e       k;
      logic [7:0]  flen;
      status_e     st;
      bit          last;
      logic [3:0]  got;
      logic [63:0] v;
      fed++;
      if (r.req_type == REQ_HEADER) begin
        table_entry(r.opt_code, k, flen);
        st = ST_OK;
        if (k == KIND_UNKNOWN) st = ST_UNKNOWN_CODE;
        else if (flen != LEN_VAR && flen != r.opt_length) st = ST_LEN_MISMATCH;
        else if (k == KIND_NONE) st = ST_EMPTY_TYPE;
        else if (k == KIND_BYTE_ARRAY &&
                 r.opt_length < ((r.opt_code == OPT_CLIENT_ID) ? 8'd2 : 8'd1))
          st = ST_BELOW_MIN;
        elem_acc   = '0;
        elem_seen  = '0;
        cur_code   = r.opt_code;
        cur_kind   = (st != ST_OK) ? KIND_SUBNET_MASK : k;
        bytes_left = r.opt_length;
        is_open    = (r.opt_length != 8'd0);
        is_failed  = is_open && (st != ST_OK);
        if (st != ST_OK) expect_element('0, KIND_SUBNET_MASK, st, 1'b1);
        return;
      end
      if (!is_open) begin
        expect_element({56'd0, r.payload_byte}, KIND_SUBNET_MASK, ST_STRAY, 1'b0);
        return;
      end
      bytes_left = bytes_left - 8'd1;
      last = (bytes_left == 8'd0);
      if (last) is_open = 1'b0;
      if (is_failed) begin
        if (last) is_failed = 1'b0;
        return;
      end
      if (cur_kind inside {KIND_STRING, KIND_BYTE_ARRAY, KIND_VENDOR}) begin
        expect_element({56'd0, r.payload_byte}, cur_kind, ST_OK, last);
        return;
      end
      elem_acc = {elem_acc[55:0], r.payload_byte};
      got = {1'b0, elem_seen} + 4'd1;
      if (got >= bytes_per_element(cur_kind)) begin
        v  = elem_acc;
        st = ST_OK;
        if (cur_kind == KIND_FLAG) v = (v != 64'd0) ? 64'd1 : 64'd0;
        else if (cur_kind inside {KIND_UINT8, KIND_UINT16, KIND_UINT32, KIND_ENUM})
          st = value_status(cur_code, v);
        elem_acc  = '0;
        elem_seen = '0;
        expect_element(v, cur_kind, st, last);
        return;
      end
      if (last) begin
        expect_element(elem_acc, cur_kind, ST_PARTIAL, 1'b1);
        elem_acc  = '0;
        elem_seen = '0;
        return;
      end
      elem_seen = got[2:0];
    endfunction

    function void match_result(input dopc_rsp_t a);
      dopc_rsp_t e;
      if (pending_elements.size() == 0) begin
        $error("unexpected result: element_value %h value_kind %0d status %0d is_last %0d",
               a.element_value, a.value_kind, a.status, a.is_last);
        errors++;
        return;
      end
      e = pending_elements.pop_front();
      if (a.element_value !== e.element_value) begin
        $error("element_value: expected %h, actual %h", e.element_value, a.element_value);
        errors++;
      end
      if (a.value_kind !== e.value_kind) begin
        $error("value_kind: expected %0d, actual %0d", e.value_kind, a.value_kind);
        errors++;
      end
      if (a.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, a.status);
        errors++;
      end
      if (a.is_last !== e.is_last) begin
        $error("is_last: expected %0d, actual %0d", e.is_last, a.is_last);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned ITEMS = 1100;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst_n;
  logic      req_valid;
  logic      req_ready;
  dopc_req_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  dopc_rsp_t rsp;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycles;
  dhcp_option_tracker tracker;

  dhcp_option_payload_checker i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && rsp_valid && rsp_ready) tracker.match_result(rsp);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(0, 9));
      default: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task automatic send_item(input dopc_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    tracker.take_request(r);
    @(negedge clk);
  endtask

  task automatic send_header(input logic [7:0] code, input logic [7:0] len);
    dopc_req_t r;
    r.req_type     = REQ_HEADER;
    r.opt_code     = code;
    r.opt_length   = len;
    r.payload_byte = 8'($urandom_range(0, 255));
    send_item(r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    dopc_req_t r;
    r.req_type     = REQ_PAYLOAD;
    r.opt_code     = 8'($urandom_range(0, 255));
    r.opt_length   = 8'($urandom_range(0, 255));
    r.payload_byte = b;
    send_item(r);
  endtask

  task automatic send_good_option();
    logic [7:0] code;
    logic [7:0] len;
    logic [7:0] flen;
    kind_e      k;
    code = 8'($urandom_range(0, 76));
    tracker.table_entry(code, k, flen);
    if (flen != LEN_VAR) begin
      len = flen;
      if ($urandom_range(0, 19) == 0) len = 8'($urandom_range(0, 9));
    end else if ($urandom_range(0, 39) == 0) begin
      len = 8'($urandom_range(13, 255));
    end else begin
      case (k)
        KIND_IP_MASK, KIND_IP_PAIR: len = 8'(8 * $urandom_range(0, 2));
        KIND_UINT16: len = 8'(2 * $urandom_range(0, 4));
        KIND_IP_ADDR: len = 8'(4 * $urandom_range(0, 3));
        default: len = 8'($urandom_range(0, 12));
      endcase
      if ($urandom_range(0, 9) == 0) len = len + 8'd1;
    end
    send_header(code, len);
    repeat (len) send_byte(pick_byte());
  endtask

  initial begin
    int unsigned choice;
    logic [7:0]  len;
    tracker        = new();
    rst_n          = 1'b0;
    req_valid      = 1'b0;
    req            = '0;
    send_idle_pct  = 11;
    recv_stall_pct = 48;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corner cases
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(OPT_END, 8'd0);
    send_header(8'd62, 8'd0);
    send_header(OPT_CLIENT_ID, 8'd1);
    send_byte(8'h5A);
    send_header(OPT_MSG_TYPE, 8'd1);
    send_byte(8'h00);
    send_header(8'd1, 8'd3);
    send_header(8'd21, 8'd8);
    repeat (8) send_byte(8'hFF);
    send_header(8'd33, 8'd3);
    send_byte(8'hC0);
    send_byte(8'hA8);
    send_byte(8'h01);
    send_header(8'd12, 8'd0);
    send_header(8'd19, 8'd1);
    send_byte(8'h80);

    while (tracker.fed < ITEMS) begin
      if (tracker.fed >= 2 * ITEMS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (tracker.fed >= ITEMS / 3) begin
        send_idle_pct  = 48;
        recv_stall_pct = 11;
      end
      choice = $urandom_range(0, 99);
      if (choice < 80) begin
        send_good_option();
      end else if (choice < 88) begin
        len = 8'($urandom_range(2, 12));
        send_header(8'($urandom_range(0, 76)), len);
        repeat ($urandom_range(1, len - 1)) send_byte(pick_byte());
      end else if (choice < 94) begin
        repeat ($urandom_range(1, 3)) send_byte(pick_byte());
      end else begin
        len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 10));
        send_header(8'($urandom_range(0, 255)), len);
        repeat (len) send_byte(pick_byte());
      end
    end
    req_valid <= 1'b0;

    while (tracker.pending_elements.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
